// ----- hw/rtl/bba_pkg.sv -----
// Shared types and constants of the bitmap block allocator.
`default_nettype none

package bba_pkg;

    localparam int REQ_W = 3;
    localparam int BLK_W = 16;
    localparam int REG_W = 17;
    localparam int IN_TDATA_W = 24;
    localparam int OUT_TDATA_W = 40;

    typedef logic [REQ_W-1:0] t_req;
    typedef logic [BLK_W-1:0] t_blk;
    typedef logic [REG_W-1:0] t_reg;
    typedef logic [0:0] t_cfg_idx;

    localparam t_req REQ_FORMAT = 3'd0;
    localparam t_req REQ_ALLOC  = 3'd1;
    localparam t_req REQ_FREE   = 3'd2;
    localparam t_req REQ_WRITE  = 3'd3;
    localparam t_req REQ_READ   = 3'd4;

    localparam t_cfg_idx CFG_TOTAL = 1'b0;
    localparam t_cfg_idx CFG_META  = 1'b1;

    localparam t_reg TOTAL_RESET  = 17'd65536;
    localparam t_reg RESULT_REACH = 17'd65536;
    localparam t_reg COUNT_MAX    = 17'h1FFFF;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_FMT,
        S_SCAN,
        S_MRD,
        S_MWR,
        S_DONE
    } t_state;

    typedef struct packed {
        logic accept;
        logic fmt_init;
        logic sweep;
        logic scan_init;
        logic scan_step;
        logic no_free;
        logic div;
        logic mrd;
        logic mwr;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        t_req req;
        logic count_zero;
        logic sweep_last;
        logic scan_done;
        logic out_free;
    } t_stat;

endpackage

`default_nettype wire

// ----- hw/rtl/bba_ctrl.sv -----
// Sequencer of the bitmap block allocator.
`default_nettype none

module bba_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire bba_pkg::t_stat i_stat,
    output bba_pkg::t_cmd      o_cmd
);
    import bba_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (i_stat.sweep_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_valid) n_state = S_DECODE;
            end
            S_DECODE: begin
                unique case (i_stat.req)
                    REQ_FORMAT: n_state = S_FMT;
                    REQ_ALLOC:  n_state = i_stat.count_zero ? S_DONE : S_SCAN;
                    REQ_FREE, REQ_WRITE, REQ_READ: n_state = S_MRD;
                    default:    n_state = S_DONE;
                endcase
            end
            S_FMT: begin
                if (i_stat.sweep_last) n_state = S_DONE;
            end
            S_SCAN: begin
                if (i_stat.scan_done) n_state = S_DONE;
            end
            S_MRD:  n_state = S_MWR;
            S_MWR:  n_state = S_DONE;
            S_DONE: begin
                if (i_stat.out_free) n_state = S_IDLE;
            end
            default: n_state = S_CLEAR;
        endcase
    end

    always_comb begin
        o_cmd   = '0;
        o_ready = 1'b0;
        unique case (r_state)
            S_CLEAR: o_cmd.sweep = 1'b1;
            S_IDLE: begin
                o_ready      = 1'b1;
                o_cmd.accept = i_valid;
            end
            S_DECODE: begin
                unique case (i_stat.req)
                    REQ_FORMAT: o_cmd.fmt_init = 1'b1;
                    REQ_ALLOC: begin
                        o_cmd.no_free   = i_stat.count_zero;
                        o_cmd.scan_init = !i_stat.count_zero;
                    end
                    REQ_FREE, REQ_WRITE, REQ_READ: o_cmd.div = 1'b1;
                    default: ;
                endcase
            end
            S_FMT:  o_cmd.sweep     = 1'b1;
            S_SCAN: o_cmd.scan_step = 1'b1;
            S_MRD:  o_cmd.mrd       = 1'b1;
            S_MWR:  o_cmd.mwr       = 1'b1;
            S_DONE: o_cmd.load_out  = i_stat.out_free;
            default: ;
        endcase
    end

    a_accept_decodes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.accept |=> r_state == S_DECODE)
        else $error("accepted word not decoded");

endmodule

`default_nettype wire

// ----- hw/rtl/bba_dp.sv -----
// Datapath of the bitmap block allocator: map memory, counters, scan and result register.
`default_nettype none

module bba_dp #(
    parameter int NUM_BLOCKS    = 65536,
    parameter int MAP_WORD_BITS = 32
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire bba_pkg::t_cmd                 i_cmd,
    output bba_pkg::t_stat                     o_stat,
    input  wire bba_pkg::t_req                 i_req,
    input  wire bba_pkg::t_blk                 i_blk,
    input  wire logic                          i_val,
    input  wire logic                          i_cfg_we,
    input  wire bba_pkg::t_cfg_idx             i_cfg_addr,
    input  wire bba_pkg::t_reg                 i_cfg_wdata,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic [bba_pkg::OUT_TDATA_W-1:0]    o_out_data
);
    import bba_pkg::*;

    localparam int WB        = MAP_WORD_BITS;
    localparam int MAP_WORDS = (NUM_BLOCKS + WB - 1) / WB;
    localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int BIW       = $clog2(WB);
    localparam int CW        = $clog2(NUM_BLOCKS + 2 * WB);
    localparam int LW        = ((CW > REG_W) ? CW : REG_W) + 1;
    // reciprocal of the word width, exact for every 16-bit block number
    localparam int    SH    = 23;
    localparam longint RECIP = ((longint'(1) << SH) + WB - 1) / WB;
    localparam int    RW    = $clog2(RECIP + 1);
    localparam int    PW    = BLK_W + RW;
    localparam logic [AW-1:0] LAST_ADDR = AW'(MAP_WORDS - 1);

    logic [WB-1:0] mem [MAP_WORDS];

    t_reg          r_total, r_meta_cfg, r_meta, r_count;
    t_req          r_req;
    t_blk          r_blk, r_q, r_res;
    logic          r_val, r_rd, r_status;
    logic [AW-1:0] r_addr;
    logic [CW-1:0] r_base;
    logic [BIW-1:0] r_bit;
    logic [WB-1:0] r_rdata;
    logic          r_ovalid;
    logic [OUT_TDATA_W-1:0] r_odata;

    t_reg          tot, meta_clamp;
    logic          in_map;
    logic          sweep_last, scan_last;
    logic [WB-1:0] fmt_mask, cand, iso, upd;
    logic          found;
    logic [BIW-1:0] idx;
    logic [PW-1:0] prod;
    t_blk          qm;
    logic          mem_we, mem_re;
    logic [AW-1:0] wa, ra;
    logic [WB-1:0] wd;
    logic [LW-1:0] base_ext;

    // bit i set when base + i lies below lim
    function automatic logic [WB-1:0] prefix_mask(input t_reg lim, input logic [CW-1:0] base);
        logic [LW-1:0] l, b, k;
        logic [WB-1:0] m;
        l = LW'(lim);
        b = LW'(base);
        k = '0;
        m = '0;
        if (l >= b + LW'(WB)) begin
            m = '1;
        end else if (l > b) begin
            k = l - b;
            m = ~({WB{1'b1}} << k[BIW:0]);
        end
        return m;
    endfunction

    always_comb begin
        tot = r_total;
        if (32'(tot) > NUM_BLOCKS) tot = REG_W'(NUM_BLOCKS);
        if (tot > RESULT_REACH) tot = RESULT_REACH;
        meta_clamp = (r_meta_cfg > tot) ? tot : r_meta_cfg;
    end

    assign in_map     = 32'(r_blk) < NUM_BLOCKS;
    assign base_ext   = LW'(r_base);
    assign sweep_last = r_addr == LAST_ADDR;
    assign scan_last  = (base_ext + LW'(WB) >= LW'(tot)) || (r_addr == LAST_ADDR);
    assign fmt_mask   = prefix_mask(r_meta, r_base);
    assign cand       = ~r_rdata & prefix_mask(tot, r_base);
    assign found      = |cand;
    assign iso        = cand & (~cand + WB'(1));
    assign prod       = PW'(r_blk) * PW'(RECIP);
    assign qm         = BLK_W'(r_q * BLK_W'(WB));

    always_comb begin
        idx = '0;
        for (int i = 0; i < WB; i++) begin
            if (iso[i]) idx = idx | BIW'(i);
        end
    end

    always_comb begin
        upd = r_rdata;
        upd[r_bit] = (r_req == REQ_WRITE) ? r_val : 1'b0;
    end

    // memory port selection
    always_comb begin
        mem_we = 1'b0;
        wa     = r_addr;
        wd     = fmt_mask;
        mem_re = 1'b0;
        ra     = '0;
        if (i_cmd.sweep) begin
            mem_we = 1'b1;
        end else if (i_cmd.scan_step) begin
            mem_we = found;
            wd     = r_rdata | iso;
            mem_re = !scan_last;
            ra     = r_addr + AW'(1);
        end else if (i_cmd.mwr) begin
            mem_we = in_map && (r_req == REQ_FREE || r_req == REQ_WRITE);
            wa     = AW'(r_q);
            wd     = upd;
        end
        if (i_cmd.scan_init) begin
            mem_re = 1'b1;
        end else if (i_cmd.mrd) begin
            mem_re = in_map;
            ra     = AW'(r_q);
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) mem[wa] <= wd;
        if (mem_re) r_rdata <= mem[ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total    <= TOTAL_RESET;
            r_meta_cfg <= '0;
            r_meta     <= '0;
            r_count    <= TOTAL_RESET;
            r_addr     <= '0;
            r_base     <= '0;
            r_ovalid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    CFG_TOTAL: r_total    <= i_cfg_wdata;
                    CFG_META:  r_meta_cfg <= i_cfg_wdata;
                    default: ;
                endcase
            end
            if (i_cmd.fmt_init) begin
                r_meta  <= meta_clamp;
                r_count <= tot - meta_clamp;
                r_addr  <= '0;
                r_base  <= '0;
            end
            if (i_cmd.scan_init) begin
                r_addr <= '0;
                r_base <= '0;
            end
            if (i_cmd.sweep) begin
                r_addr <= sweep_last ? '0 : r_addr + AW'(1);
                r_base <= sweep_last ? '0 : r_base + CW'(WB);
            end
            if (i_cmd.scan_step && !found) begin
                r_addr <= r_addr + AW'(1);
                r_base <= r_base + CW'(WB);
            end
            if (i_cmd.scan_step && found) r_count <= r_count - REG_W'(1);
            if (i_cmd.mwr && r_req == REQ_FREE && r_count != COUNT_MAX) begin
                r_count <= r_count + REG_W'(1);
            end
            if (i_cmd.load_out) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // request payload and result fields
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_req    <= i_req;
            r_blk    <= i_blk;
            r_val    <= i_val;
            r_res    <= '0;
            r_rd     <= 1'b0;
            r_status <= 1'b0;
        end
        if (i_cmd.no_free) r_status <= 1'b1;
        if (i_cmd.scan_step) begin
            if (found) begin
                r_res <= BLK_W'(base_ext + LW'(idx));
            end else if (scan_last) begin
                r_status <= 1'b1;
            end
        end
        if (i_cmd.div) r_q <= BLK_W'(prod >> SH);
        if (i_cmd.mrd) r_bit <= BIW'(r_blk - qm);
        if (i_cmd.mwr) begin
            if (r_req == REQ_FREE) r_res <= r_blk;
            if (r_req == REQ_READ) r_rd <= in_map & r_rdata[r_bit];
        end
        if (i_cmd.load_out) begin
            r_odata <= {5'd0, r_count, r_status, r_rd, r_res};
        end
    end

    assign o_stat.req        = r_req;
    assign o_stat.count_zero = r_count == '0;
    assign o_stat.sweep_last = sweep_last;
    assign o_stat.scan_done  = found || scan_last;
    assign o_stat.out_free   = !r_ovalid || i_out_ready;
    assign o_out_valid       = r_ovalid;
    assign o_out_data        = r_odata;

    a_alloc_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.scan_step && found |-> r_count != '0)
        else $error("block allocated with zero free count");

    a_write_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> wa <= LAST_ADDR)
        else $error("map write beyond last word");

    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_out |=> r_ovalid)
        else $error("loaded result not presented");

endmodule

`default_nettype wire

// ----- hw/rtl/bitmap_block_allocator.sv -----
// Top level of the first-fit bitmap block allocator.
//
// Input stream: one request word per transfer; tuser carries the request kind
// (format, allocate, free, write bit, read bit), tdata the block number and the
// bit value. Output stream: one result word per request with the block number,
// the bit read, the failure flag and the free count after the request.
// Two registers (total blocks, metadata blocks) are written through the plain
// config port; the user must write them only while no request is in flight, which
// the block does not enforce. Free, write bit and read bit divide the block
// number by the word width and read the map word, which free and write bit then
// write back; allocate reads the map words in order (one memory read a cycle)
// up to the first free block in range or the last word; format writes every map
// word once. One request is worked at a time. After reset the map memory is
// cleared one word a cycle, with tready low; the registers return to their reset
// values at once. The result register lets the next request be accepted while a
// result waits; a stalled receiver holds the sequencer at its last step.
`default_nettype none

module bitmap_block_allocator #(
    parameter int NUM_BLOCKS    = 65536,
    parameter int MAP_WORD_BITS = 32
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    // [15:0] block_number, [16] bit_value, rest zero
    input  wire logic [bba_pkg::IN_TDATA_W-1:0] i_s_axis_tdata,
    // [2:0] req_type
    input  wire logic [bba_pkg::REQ_W-1:0]   i_s_axis_tuser,
    output logic                             o_m_axis_tvalid,
    input  wire logic                        i_m_axis_tready,
    // [15:0] result_block, [16] bit_read, [17] status, [34:18] free_blocks
    output logic [bba_pkg::OUT_TDATA_W-1:0]  o_m_axis_tdata,
    input  wire logic                        i_cfg_we,
    input  wire bba_pkg::t_cfg_idx           i_cfg_addr,
    input  wire bba_pkg::t_reg               i_cfg_wdata
);
    import bba_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    bba_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    bba_dp #(
        .NUM_BLOCKS    (NUM_BLOCKS),
        .MAP_WORD_BITS (MAP_WORD_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_req       (i_s_axis_tuser),
        .i_blk       (i_s_axis_tdata[BLK_W-1:0]),
        .i_val       (i_s_axis_tdata[BLK_W]),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_out_data  (o_m_axis_tdata)
    );

endmodule

`default_nettype wire
